>>> rtl/core/tjq_pkg.sv
package tjq_pkg;

   // Command codes on req_opcode.
   localparam logic [2:0] OP_POST   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_EXISTS = 3'd3;
   localparam logic [2:0] OP_FLUSH  = 3'd4;

   localparam int TIME_W  = 48;
   localparam int JOB_W   = 16;
   localparam int DELAY_W = 32;
   localparam int WAIT_W  = 49;
   localparam int SLACK_W = 20;

   localparam logic [SLACK_W-1:0] SLACK_RESET = 20'd1000;

   // One stored job: due time and handle.
   typedef struct packed {
      logic [TIME_W-1:0] due;
      logic [JOB_W-1:0]  handle;
   } entry_type;

   localparam int ENTRY_W = TIME_W + JOB_W;

endpackage

>>> rtl/core/tjq_ram.sv
module tjq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/timed_job_queue_unit.sv
// Flush, FIFO post, full post and unknown codes answer in the cycle after start.
// Pop checks the timed head and, when it leaves, shifts the remaining timed entries down.
// Timed post walks the timed list from its tail, one entry per cycle.
// Remove and exists merge each FIFO entry by such a walk, then scan the list once.
// One command at a time; a walking command holds busy high until its result strobe.
// The receiver cannot stall; reset empties both stores and restores the default slack.
module timed_job_queue_unit #(
   parameter int JOB_CAPACITY = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_opcode,
   input  logic [15:0]                  req_job_id,
   input  logic signed [31:0]           req_delay_us,
   input  logic [47:0]                  req_now_us,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [15:0]                  rsp_out_job_id,
   output logic signed [48:0]           rsp_wait_us,
   output logic                         rsp_wake,
   output logic                         rsp_full_error,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [19:0]                  csr_due_slack_us
);

   localparam int AW = $clog2(JOB_CAPACITY);
   localparam int CW = $clog2(JOB_CAPACITY + 1);
   localparam logic [CW:0] CAP_W = (CW+1)'(JOB_CAPACITY);
   localparam int TW = tjq_pkg::TIME_W;

   typedef enum logic [3:0] {
      IDLE, MRG_RD, MRG_GO, INS_WALK, INS_LAST, POP_CHK, POP_SHIFT, SCAN_ISSUE, SCAN
   } state_type;

   state_type state_ff;
   logic [2:0]  op_ff;
   logic [15:0] job_ff;
   logic [TW-1:0] now_ff;
   tjq_pkg::entry_type new_ff;
   logic strict_ff;
   logic [CW-1:0] k_ff, w_ff, tcount_ff, fcount_ff;
   logic [AW-1:0] head_ff;
   logic [tjq_pkg::SLACK_W-1:0] slack_ff;
   logic valid_ff, found_ff, wake_ff, full_ff;
   logic [15:0] ojob_ff;
   logic [48:0] wait_ff;

   logic t_we, f_we;
   logic [AW-1:0] t_wa, t_ra, f_wa;
   tjq_pkg::entry_type t_wd, f_wd, t_rd, f_rd;
   logic [tjq_pkg::ENTRY_W-1:0] t_rd_raw, f_rd_raw;

   // Memories for the timed list and the FIFO ring.
   tjq_ram #(.WIDTH(tjq_pkg::ENTRY_W), .DEPTH(JOB_CAPACITY)) u_timed (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd_raw)
   );
   tjq_ram #(.WIDTH(tjq_pkg::ENTRY_W), .DEPTH(JOB_CAPACITY)) u_fifo (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(head_ff), .rd_data(f_rd_raw)
   );
   assign t_rd = t_rd_raw;
   assign f_rd = f_rd_raw;

   // Handshake and command decode helpers.
   logic accept, is_full, shift, match, t_due;
   logic [CW:0] tail_sum, total;
   logic [AW-1:0] tail, head_inc;
   logic [48:0] post_sum, due_lim;
   logic [TW-1:0] post_t;
   logic [CW-1:0] w_next;

   assign accept   = start && (state_ff == IDLE);
   assign busy     = (state_ff != IDLE);
   assign csr_ready = 1'b1;
   assign total    = (CW+1)'(tcount_ff) + (CW+1)'(fcount_ff);
   assign is_full  = (total >= CAP_W);
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(fcount_ff);
   assign tail     = (tail_sum >= CAP_W) ? AW'(tail_sum - CAP_W) : AW'(tail_sum);
   assign head_inc = ((CW+1)'(head_ff) + 1'b1 == CAP_W) ? '0 : head_ff + 1'b1;

   // Due time of a timed post, saturated to the time width.
   assign post_sum = {1'b0, req_now_us}
                   + (req_delay_us[31] ? 49'd0 : 49'(req_delay_us[30:0]));
   assign post_t   = post_sum[48] ? '1 : post_sum[TW-1:0];

   // Comparisons on the entry coming back from the timed memory.
   assign shift  = strict_ff ? (t_rd.due > new_ff.due) : (t_rd.due >= new_ff.due);
   assign match  = (t_rd.handle == job_ff);
   assign due_lim = {1'b0, now_ff} + 49'(slack_ff);
   assign t_due  = ({1'b0, t_rd.due} <= due_lim);
   assign w_next = match ? w_ff : w_ff + 1'b1;

   // Memory ports driven from the sequencer state.
   always_comb begin
      t_ra = '0;
      t_we = 1'b0;
      t_wa = '0;
      t_wd = new_ff;
      f_we = accept && (req_opcode == tjq_pkg::OP_POST) && !is_full && (req_delay_us == '0);
      f_wa = tail;
      f_wd = '{due: req_now_us, handle: req_job_id};
      case (state_ff)
         IDLE: begin
            // A pop needs the head; a timed post starts its walk at the tail.
            t_ra = (req_opcode == tjq_pkg::OP_POP) ? '0 : AW'(tcount_ff - 1'b1);
         end
         MRG_GO: begin
            t_ra = AW'(tcount_ff - 1'b1);
         end
         INS_WALK: begin
            t_ra = AW'(k_ff - 1'b1);
            t_we = 1'b1;
            t_wa = AW'(k_ff + 1'b1);
            t_wd = shift ? t_rd : new_ff;
         end
         INS_LAST: begin
            t_we = 1'b1;
         end
         POP_CHK: begin
            t_ra = AW'(1);
         end
         POP_SHIFT: begin
            t_ra = AW'(k_ff + 1'b1);
            t_we = 1'b1;
            t_wa = AW'(k_ff - 1'b1);
            t_wd = t_rd;
         end
         SCAN_ISSUE: begin
            t_ra = '0;
         end
         SCAN: begin
            t_ra = AW'(k_ff + 1'b1);
            t_we = (op_ff == tjq_pkg::OP_REMOVE) && !match;
            t_wa = AW'(w_ff);
            t_wd = t_rd;
         end
         default: begin
            t_ra = '0;
         end
      endcase
   end

   // Sequencer: state, counts and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         tcount_ff <= '0;
         fcount_ff <= '0;
         head_ff   <= '0;
         slack_ff  <= tjq_pkg::SLACK_RESET;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_valid) begin
            slack_ff <= csr_due_slack_us;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  op_ff    <= req_opcode;
                  job_ff   <= req_job_id;
                  now_ff   <= req_now_us;
                  found_ff <= 1'b0;
                  ojob_ff  <= '0;
                  wait_ff  <= '0;
                  wake_ff  <= 1'b0;
                  full_ff  <= 1'b0;
                  case (req_opcode)
                     tjq_pkg::OP_POST: begin
                        if (is_full) begin
                           full_ff  <= 1'b1;
                           valid_ff <= 1'b1;
                        end else if (req_delay_us == '0) begin
                           fcount_ff <= fcount_ff + 1'b1;
                           wake_ff   <= 1'b1;
                           valid_ff  <= 1'b1;
                        end else begin
                           new_ff    <= '{due: post_t, handle: req_job_id};
                           strict_ff <= 1'b0;
                           k_ff      <= tcount_ff - 1'b1;
                           state_ff  <= (tcount_ff == '0) ? INS_LAST : INS_WALK;
                        end
                     end
                     tjq_pkg::OP_POP: begin
                        state_ff <= POP_CHK;
                     end
                     tjq_pkg::OP_REMOVE, tjq_pkg::OP_EXISTS: begin
                        state_ff <= (fcount_ff != '0) ? MRG_RD : SCAN_ISSUE;
                     end
                     tjq_pkg::OP_FLUSH: begin
                        tcount_ff <= '0;
                        fcount_ff <= '0;
                        head_ff   <= '0;
                        wake_ff   <= 1'b1;
                        valid_ff  <= 1'b1;
                     end
                     default: begin
                        valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            MRG_RD: begin
               state_ff <= MRG_GO;
            end
            MRG_GO: begin
               new_ff    <= f_rd;
               strict_ff <= 1'b1;
               k_ff      <= tcount_ff - 1'b1;
               state_ff  <= (tcount_ff == '0) ? INS_LAST : INS_WALK;
            end
            INS_WALK, INS_LAST: begin
               if (state_ff == INS_WALK && shift) begin
                  k_ff <= k_ff - 1'b1;
                  if (k_ff == '0) begin
                     state_ff <= INS_LAST;
                  end
               end else begin
                  // Insertion done: the new entry was written this cycle.
                  tcount_ff <= tcount_ff + 1'b1;
                  if (strict_ff) begin
                     if (fcount_ff == CW'(1)) begin
                        head_ff   <= '0;
                        fcount_ff <= '0;
                        state_ff  <= SCAN_ISSUE;
                     end else begin
                        head_ff   <= head_inc;
                        fcount_ff <= fcount_ff - 1'b1;
                        state_ff  <= MRG_RD;
                     end
                  end else begin
                     wake_ff  <= (state_ff == INS_LAST);
                     valid_ff <= 1'b1;
                     state_ff <= IDLE;
                  end
               end
            end
            POP_CHK: begin
               wait_ff <= '1;
               if (tcount_ff != '0 && t_due) begin
                  found_ff <= 1'b1;
                  ojob_ff  <= t_rd.handle;
                  k_ff     <= CW'(1);
                  if (tcount_ff == CW'(1)) begin
                     tcount_ff <= '0;
                     valid_ff  <= 1'b1;
                     state_ff  <= IDLE;
                  end else begin
                     state_ff <= POP_SHIFT;
                  end
               end else begin
                  if (tcount_ff != '0) begin
                     wait_ff <= {1'b0, t_rd.due} - {1'b0, now_ff};
                  end
                  if (fcount_ff != '0) begin
                     found_ff  <= 1'b1;
                     ojob_ff   <= f_rd.handle;
                     head_ff   <= head_inc;
                     fcount_ff <= fcount_ff - 1'b1;
                  end
                  valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            POP_SHIFT: begin
               if (k_ff == tcount_ff - 1'b1) begin
                  tcount_ff <= tcount_ff - 1'b1;
                  valid_ff  <= 1'b1;
                  state_ff  <= IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            SCAN_ISSUE: begin
               k_ff <= '0;
               w_ff <= '0;
               if (tcount_ff == '0) begin
                  valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end else begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               // Remove compacts survivors down to w; exists only looks.
               if (op_ff == tjq_pkg::OP_REMOVE) begin
                  if (match && w_ff == '0) begin
                     wake_ff <= 1'b1;
                  end
                  w_ff <= w_next;
               end else if (match) begin
                  found_ff <= 1'b1;
               end
               if (k_ff == tcount_ff - 1'b1) begin
                  if (op_ff == tjq_pkg::OP_REMOVE) begin
                     tcount_ff <= w_next;
                  end
                  valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_out_job_id = ojob_ff;
   assign rsp_wait_us    = wait_ff;
   assign rsp_wake       = wake_ff;
   assign rsp_full_error = full_ff;

endmodule

>>> rtl/core/tjq_checker.sv
module tjq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic [15:0] rsp_out_job_id,
   input logic        rsp_wake,
   input logic        rsp_full_error
);

   // After reset the unit is idle and silent.
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("unit not idle after reset");

   // Each accepted command either keeps the unit busy or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command produced neither busy nor a beat");

   // A rejected post reports nothing else.
   a_full_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_full_error) |-> (!rsp_found && !rsp_wake && rsp_out_job_id == '0))
      else $error("full error beat carries other flags");

   // No beat comes while a command is still running.
   a_no_beat_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy || $past(start && !busy))
      else $error("result beat while busy");

   // A flush always asks for a wake-up.
   a_flush_wake: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == tjq_pkg::OP_FLUSH) |=> (rsp_valid && rsp_wake))
      else $error("flush without wake beat");

endmodule

bind timed_job_queue_unit tjq_checker u_tjq_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_opcode(req_opcode), .rsp_valid(rsp_valid), .rsp_found(rsp_found),
   .rsp_out_job_id(rsp_out_job_id), .rsp_wake(rsp_wake),
   .rsp_full_error(rsp_full_error)
);

>>> tb/timed_job_queue_unit_tb.sv
`timescale 1ns / 100ps

module timed_job_queue_unit_tb;

   localparam int CAP = 64;
   localparam logic [2:0] OP_BAD5 = 3'd5;
   localparam logic [2:0] OP_BAD7 = 3'd7;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_opcode = '0;
   logic [15:0] req_job_id = '0;
   logic signed [31:0] req_delay_us = '0;
   logic [47:0] req_now_us = '0;
   logic rsp_valid, rsp_found, rsp_wake, rsp_full_error;
   logic [15:0] rsp_out_job_id;
   logic signed [48:0] rsp_wait_us;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [19:0] csr_due_slack_us = '0;

   timed_job_queue_unit #(.JOB_CAPACITY(CAP)) dut (.*);

   // Expected answer of one command.
   typedef struct packed {
      logic        found;
      logic [15:0] job;
      logic [48:0] wait_us;
      logic        wake;
      logic        full;
   } answer_type;

   // Shadow copy of the scheduler state.
   logic [47:0] sh_tdue [CAP+1];
   logic [15:0] sh_tjob [CAP+1];
   int          sh_tcnt;
   logic [47:0] sh_fdue [CAP];
   logic [15:0] sh_fjob [CAP];
   int          sh_fhead, sh_fcnt;
   logic [19:0] sh_slack;

   answer_type pending_answers[$];
   int      error_count = 0;
   int      answer_count = 0;
   int      sender_idle = 0;
   logic [47:0] clock_us = 48'd0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Fold the FIFO into the timed list, FIFO entries after equal times.
   task automatic fold_fifo_in();
      int pos;
      logic [47:0] t;
      logic [15:0] h;
      while (sh_fcnt > 0 && sh_tcnt < CAP) begin
         t = sh_fdue[sh_fhead];
         h = sh_fjob[sh_fhead];
         pos = sh_tcnt;
         while (pos > 0 && sh_tdue[pos-1] > t) begin
            sh_tdue[pos] = sh_tdue[pos-1];
            sh_tjob[pos] = sh_tjob[pos-1];
            pos--;
         end
         sh_tdue[pos] = t;
         sh_tjob[pos] = h;
         sh_tcnt++;
         sh_fhead = (sh_fhead + 1) % CAP;
         sh_fcnt--;
      end
      sh_fhead = 0;
      sh_fcnt = 0;
   endtask

   // Predict the answer of one command and advance the shadow state.
   task automatic schedule_predict(input logic [2:0] op, input logic [15:0] id,
                                   input logic signed [31:0] dly, input logic [47:0] now);
      answer_type a;
      logic [48:0] t;
      logic [48:0] lim;
      int pos, w;
      bit done;
      a = '0;
      case (op)
         tjq_pkg::OP_POST: begin
            if (sh_tcnt + sh_fcnt >= CAP) begin
               a.full = 1'b1;
            end else if (dly == 0) begin
               sh_fdue[(sh_fhead + sh_fcnt) % CAP] = now;
               sh_fjob[(sh_fhead + sh_fcnt) % CAP] = id;
               sh_fcnt++;
               a.wake = 1'b1;
            end else begin
               t = {1'b0, now} + ((dly < 0) ? 49'd0 : {17'd0, dly});
               if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
               pos = 0;
               while (pos < sh_tcnt && sh_tdue[pos] < t[47:0]) pos++;
               for (int k = sh_tcnt; k > pos; k--) begin
                  sh_tdue[k] = sh_tdue[k-1];
                  sh_tjob[k] = sh_tjob[k-1];
               end
               sh_tdue[pos] = t[47:0];
               sh_tjob[pos] = id;
               sh_tcnt++;
               if (pos == 0) a.wake = 1'b1;
            end
         end
         tjq_pkg::OP_POP: begin
            done = 0;
            a.wait_us = '1;
            if (sh_tcnt > 0) begin
               lim = {1'b0, now} + sh_slack;
               if ({1'b0, sh_tdue[0]} <= lim) begin
                  a.found = 1'b1;
                  a.job = sh_tjob[0];
                  for (int k = 1; k < sh_tcnt; k++) begin
                     sh_tdue[k-1] = sh_tdue[k];
                     sh_tjob[k-1] = sh_tjob[k];
                  end
                  sh_tcnt--;
                  done = 1;
               end else begin
                  a.wait_us = {1'b0, sh_tdue[0]} - {1'b0, now};
               end
            end
            if (!done && sh_fcnt > 0) begin
               a.found = 1'b1;
               a.job = sh_fjob[sh_fhead];
               sh_fhead = (sh_fhead + 1) % CAP;
               sh_fcnt--;
            end
         end
         tjq_pkg::OP_REMOVE: begin
            fold_fifo_in();
            w = 0;
            for (int r = 0; r < sh_tcnt; r++) begin
               if (sh_tjob[r] == id) begin
                  if (w == 0) a.wake = 1'b1;
               end else begin
                  sh_tdue[w] = sh_tdue[r];
                  sh_tjob[w] = sh_tjob[r];
                  w++;
               end
            end
            sh_tcnt = w;
         end
         tjq_pkg::OP_EXISTS: begin
            fold_fifo_in();
            for (int r = 0; r < sh_tcnt; r++)
               if (sh_tjob[r] == id) a.found = 1'b1;
         end
         tjq_pkg::OP_FLUSH: begin
            sh_tcnt = 0;
            sh_fhead = 0;
            sh_fcnt = 0;
            a.wake = 1'b1;
         end
         default: ;
      endcase
      pending_answers.push_back(a);
   endtask

   // Send one command beat, after an optional random idle gap.
   task automatic issue_command(input logic [2:0] op, input logic [15:0] id,
                                input logic signed [31:0] dly, input logic [47:0] now);
      while ($urandom_range(99) < sender_idle) @(posedge clock);
      req_opcode <= op;
      req_job_id <= id;
      req_delay_us <= dly;
      req_now_us <= now;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      schedule_predict(op, id, dly, now);
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for all answers, then idle briefly before returning.
   task automatic drain();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_slack(input logic [19:0] v);
      drain();
      csr_due_slack_us <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sh_slack = v;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Compare each answer beat with the oldest expectation.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         answer_count++;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected answer beat found=%0b job=%h", $time,
                     rsp_found, rsp_out_job_id);
            error_count++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_found !== e.found || rsp_out_job_id !== e.job ||
                rsp_wait_us !== e.wait_us || rsp_wake !== e.wake ||
                rsp_full_error !== e.full) begin
               $display("%0t: expected f=%0b j=%h w=%h wk=%0b fe=%0b", $time,
                        e.found, e.job, e.wait_us, e.wake, e.full);
               $display("%0t: actual   f=%0b j=%h w=%h wk=%0b fe=%0b", $time,
                        rsp_found, rsp_out_job_id, rsp_wait_us, rsp_wake, rsp_full_error);
               error_count++;
            end
         end
      end
   end

   // Random command; most traffic uses a few handles and a rising clock.
   task automatic random_command();
      logic [2:0] op;
      logic [15:0] id;
      logic signed [31:0] dly;
      int r;
      r = $urandom_range(99);
      op = (r < 45) ? tjq_pkg::OP_POST : (r < 75) ? tjq_pkg::OP_POP :
           (r < 85) ? tjq_pkg::OP_REMOVE : (r < 94) ? tjq_pkg::OP_EXISTS :
           (r < 97) ? tjq_pkg::OP_FLUSH : 3'($urandom_range(5, 7));
      id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      case ($urandom_range(5))
         0, 1: dly = 0;
         2: dly = $urandom_range(3000);
         3: dly = $urandom;
         4: dly = -$signed(32'($urandom_range(5000)));
         default: dly = $urandom_range(50);
      endcase
      clock_us = clock_us + 48'($urandom_range(600));
      if ($urandom_range(200) == 0) clock_us = 48'({$urandom, $urandom}) & TIME_MAX;
      issue_command(op, id, dly, clock_us);
   endtask

   task automatic test_directed_extremes();
      issue_command(tjq_pkg::OP_POP, 16'h0, 0, 48'd0);
      issue_command(tjq_pkg::OP_POST, 16'hFFFF, 0, 48'd5);
      issue_command(tjq_pkg::OP_POST, 16'h0001, 32'sh7FFF_FFFF, TIME_MAX);
      issue_command(tjq_pkg::OP_POST, 16'h0002, 32'sh8000_0000, 48'd10);
      issue_command(tjq_pkg::OP_POST, 16'h0003, 100, 48'd10);
      issue_command(tjq_pkg::OP_POST, 16'h0004, 100, 48'd10);
      issue_command(tjq_pkg::OP_EXISTS, 16'hFFFF, 0, 48'd11);
      issue_command(tjq_pkg::OP_EXISTS, 16'h1234, 0, 48'd11);
      issue_command(tjq_pkg::OP_POP, 16'h0, 0, 48'd0);
      issue_command(tjq_pkg::OP_POP, 16'h0, 0, 48'd0);
      issue_command(tjq_pkg::OP_REMOVE, 16'h0004, 0, 48'd12);
      issue_command(tjq_pkg::OP_POP, 16'h0, 0, 48'd0);
      issue_command(tjq_pkg::OP_POP, 16'h0, 0, 48'd0);
      issue_command(OP_BAD5, 16'hFFFF, -1, TIME_MAX);
      issue_command(OP_BAD7, 16'hFFFF, -1, TIME_MAX);
      issue_command(tjq_pkg::OP_FLUSH, 16'h0, 0, 48'd0);
   endtask

   task automatic test_full_store();
      for (int i = 0; i < CAP + 2; i++)
         issue_command(tjq_pkg::OP_POST, 16'(i), (i % 2) ? 0 : 32'(i * 7 + 1), 48'd1000);
      issue_command(tjq_pkg::OP_REMOVE, 16'd3, 0, 48'd1000);
      issue_command(tjq_pkg::OP_EXISTS, 16'd4, 0, 48'd1000);
      issue_command(tjq_pkg::OP_FLUSH, 16'h0, 0, 48'd0);
   endtask

   task automatic test_random_phase(input int count, input int idle);
      sender_idle = idle;
      for (int i = 0; i < count; i++) random_command();
   endtask

   initial begin
      sh_tcnt = 0;
      sh_fhead = 0;
      sh_fcnt = 0;
      sh_slack = tjq_pkg::SLACK_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_full_store();
      test_random_phase(560, 36);
      write_slack(20'd0);
      test_random_phase(560, 75);
      write_slack(20'hFFFFF);
      test_random_phase(300, 0);
      write_slack(20'd250);
      test_random_phase(300, 0);
      drain();
      $display("Ran directed edge cases, a full store and about 1800 commands in all");
      $display("over four slack settings; %0d answers checked.", answer_count);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #1s;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
